>>> rtl/core/tpa_pkg.sv
package tpa_pkg;

  // field and state widths
  localparam int KIND_W  = 2;
  localparam int VAL_W   = 16;
  localparam int GAIN_W  = 16;
  localparam int ISUM_W  = 32;
  localparam int CTL_W   = 12;
  localparam int REG_IDX_W = 3;
  localparam int NUM_REGS  = 8;

  // fixed-point constants
  localparam int GAIN_FRAC    = 8;
  localparam int INTEG_MARGIN = 300;
  localparam int OUT_MARGIN   = 100;

  // item kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_ROLL  = 2'd0,
    KIND_PITCH = 2'd1,
    KIND_YAW   = 2'd2,
    KIND_CLEAR = 2'd3
  } tpa_kind_t;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_ROLL_PROP   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ROLL_INTEG  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ROLL_DERIV  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_PITCH_PROP  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_PITCH_INTEG = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_PITCH_DERIV = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_YAW_PROP    = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_YAW_INTEG   = 3'd7;

  localparam logic [GAIN_W-1:0] GAIN_RESET [NUM_REGS] = '{
    16'd256, 16'd0, 16'd2560, 16'd256, 16'd0, 16'd2560, 16'd2560, 16'd0
  };

  // gains of the selected axis
  typedef struct packed {
    logic [GAIN_W-1:0] prop;
    logic [GAIN_W-1:0] integ;
    logic [GAIN_W-1:0] deriv;
  } tpa_gains_t;

  // state memory access for one cycle
  typedef struct packed {
    logic                     rd_en;
    tpa_kind_t                rd_axis;
    logic                     wr_isum_en;
    logic                     wr_rate_en;
    tpa_kind_t                wr_axis;
    logic                     clr;
    logic signed [ISUM_W-1:0] isum_wdata;
    logic signed [VAL_W-1:0]  rate_wdata;
  } tpa_mem_req_t;

endpackage

>>> rtl/core/tpa_gain_regs.sv
module tpa_gain_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [tpa_pkg::REG_IDX_W-1:0]    cfg_index,
  input  logic [tpa_pkg::GAIN_W-1:0]       cfg_wdata,
  input  tpa_pkg::tpa_kind_t               sel_kind,
  output tpa_pkg::tpa_gains_t              gains
);

  logic [tpa_pkg::GAIN_W-1:0] gain_r [tpa_pkg::NUM_REGS];

  // register file, one write per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < tpa_pkg::NUM_REGS; i++) begin
        gain_r[i] <= tpa_pkg::GAIN_RESET[i];
      end
    end else if (cfg_wr_en) begin
      gain_r[cfg_index] <= cfg_wdata;
    end
  end

  // per-axis gain select, yaw has no derivative term
  always_comb begin
    gains = '0;
    case (sel_kind)
      tpa_pkg::KIND_ROLL: begin
        gains.prop  = gain_r[tpa_pkg::REG_ROLL_PROP];
        gains.integ = gain_r[tpa_pkg::REG_ROLL_INTEG];
        gains.deriv = gain_r[tpa_pkg::REG_ROLL_DERIV];
      end
      tpa_pkg::KIND_PITCH: begin
        gains.prop  = gain_r[tpa_pkg::REG_PITCH_PROP];
        gains.integ = gain_r[tpa_pkg::REG_PITCH_INTEG];
        gains.deriv = gain_r[tpa_pkg::REG_PITCH_DERIV];
      end
      tpa_pkg::KIND_YAW: begin
        gains.prop  = gain_r[tpa_pkg::REG_YAW_PROP];
        gains.integ = gain_r[tpa_pkg::REG_YAW_INTEG];
      end
      default: begin
        gains = '0;
      end
    endcase
  end

endmodule

>>> rtl/core/tpa_state_mem.sv
module tpa_state_mem (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  tpa_pkg::tpa_mem_req_t                 req,
  output logic signed [tpa_pkg::ISUM_W-1:0]     isum_rd,
  output logic signed [tpa_pkg::VAL_W-1:0]      rate_rd
);

  logic signed [tpa_pkg::ISUM_W-1:0] isum_mem [3];
  logic signed [tpa_pkg::VAL_W-1:0]  rate_mem [2];
  logic [2:0]                        isum_vld_r;
  logic [1:0]                        rate_vld_r;
  logic signed [tpa_pkg::ISUM_W-1:0] isum_rd_r;
  logic signed [tpa_pkg::VAL_W-1:0]  rate_rd_r;

  // memory writes
  always_ff @(posedge clk) begin
    if (req.wr_isum_en) begin
      isum_mem[req.wr_axis] <= req.isum_wdata;
    end
    if (req.wr_rate_en) begin
      rate_mem[req.wr_axis[0]] <= req.rate_wdata;
    end
  end

  // valid bits, unwritten or cleared entries read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      isum_vld_r <= '0;
      rate_vld_r <= '0;
    end else begin
      if (req.clr) begin
        isum_vld_r <= '0;
      end else if (req.wr_isum_en) begin
        isum_vld_r[req.wr_axis] <= 1'b1;
      end
      if (req.wr_rate_en) begin
        rate_vld_r[req.wr_axis[0]] <= 1'b1;
      end
    end
  end

  // registered reads, forwarding a same-edge write or clear
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      if (req.clr || req.rd_axis == tpa_pkg::KIND_CLEAR) begin
        isum_rd_r <= '0;
      end else if (req.wr_isum_en && req.wr_axis == req.rd_axis) begin
        isum_rd_r <= req.isum_wdata;
      end else if (isum_vld_r[req.rd_axis]) begin
        isum_rd_r <= isum_mem[req.rd_axis];
      end else begin
        isum_rd_r <= '0;
      end

      if (req.wr_rate_en && req.wr_axis[0] == req.rd_axis[0]) begin
        rate_rd_r <= req.rate_wdata;
      end else if (rate_vld_r[req.rd_axis[0]]) begin
        rate_rd_r <= rate_mem[req.rd_axis[0]];
      end else begin
        rate_rd_r <= '0;
      end
    end
  end

  assign isum_rd = isum_rd_r;
  assign rate_rd = rate_rd_r;

endmodule

>>> rtl/core/three_axis_pid_attitude.sv
// result path: stage 1, stage 2, stage 3, stage 4 and the output register lie between input and result beat
// throughput: one item per cycle while out_tready keeps the pipeline moving, set by the single
//   read-modify-write of the per-axis state memory in stage 1 with same-edge forwarding
// a stalled result holds its own stage and every full stage before it, only empty stages keep filling
// reset: synchronous active-low rst_n restores gains and zeroes all state
module three_axis_pid_attitude #(
  parameter int MOTOR_MAX = 2000,
  parameter int FRAC_BITS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] angle_error, [31:16] angular_rate
  input  logic [1:0]  in_tuser,   // [1:0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [11:0] control_value, [15:12] zero
  output logic [1:0]  out_tuser,  // [1:0] axis
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int SumFrac = FRAC_BITS + tpa_pkg::GAIN_FRAC;
  localparam logic signed [33:0] IntegLim =
    34'(MOTOR_MAX - tpa_pkg::INTEG_MARGIN) << SumFrac;
  localparam logic signed [35:0] OutLim = 36'(MOTOR_MAX - tpa_pkg::OUT_MARGIN);
  localparam logic signed [35:0] FracMask = (36'sd1 <<< SumFrac) - 36'sd1;

  logic                       accept;
  logic                       en1, en2, en3, en4, en_out;
  tpa_pkg::tpa_kind_t         in_kind;
  logic signed [15:0]         in_err;
  logic signed [15:0]         in_rate;
  tpa_pkg::tpa_gains_t        gains;
  tpa_pkg::tpa_mem_req_t      mreq;
  logic signed [31:0]         isum_rd;
  logic signed [15:0]         rate_rd;

  // stage 1
  logic                       s1_v_r;
  tpa_pkg::tpa_kind_t         s1_kind_r;
  logic signed [15:0]         s1_rate_r;
  logic signed [32:0]         s1_pprod_r;
  logic signed [32:0]         s1_iprod_r;
  logic [15:0]                s1_dgain_r;
  logic signed [33:0]         s1_sum_raw;
  logic signed [31:0]         s1_sum_cl;
  logic signed [16:0]         s1_diff;

  // stage 2
  logic                       s2_v_r;
  tpa_pkg::tpa_kind_t         s2_kind_r;
  logic signed [31:0]         s2_sum_r;
  logic signed [32:0]         s2_pprod_r;
  logic signed [16:0]         s2_diff_r;
  logic [15:0]                s2_dgain_r;

  // stage 3
  logic                       s3_v_r;
  tpa_pkg::tpa_kind_t         s3_kind_r;
  logic signed [33:0]         s3_pt_r;
  logic signed [33:0]         s3_dprod_r;
  logic signed [35:0]         s3_total;

  // output stage
  logic                       out_valid_r;
  logic [15:0]                out_tdata_r;
  logic [1:0]                 out_tuser_r;
  logic signed [35:0]         s4_total_r;
  tpa_pkg::tpa_kind_t         s4_kind_r;
  logic                       s4_v_r;
  logic signed [35:0]         s4_q;
  logic signed [35:0]         s4_ctl;

  assign in_kind = tpa_pkg::tpa_kind_t'(in_tuser);
  assign in_err  = in_tdata[15:0];
  assign in_rate = in_tdata[31:16];

  // stage enables, a stage loads when it is empty or its beat moves on
  assign en_out    = !out_valid_r || out_tready;
  assign en4       = !s4_v_r || en_out;
  assign en3       = !s3_v_r || en4;
  assign en2       = !s2_v_r || en3;
  assign en1       = !s1_v_r || en2;
  assign in_tready = en1;
  assign accept    = in_tvalid && in_tready;

  tpa_gain_regs u_gain_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .sel_kind  (in_kind),
    .gains     (gains)
  );

  // state memory access: read on accept, write back as stage 1 moves on
  always_comb begin
    mreq            = '0;
    mreq.rd_en      = accept;
    mreq.rd_axis    = in_kind;
    mreq.wr_axis    = s1_kind_r;
    mreq.clr        = s1_v_r && en2 && s1_kind_r == tpa_pkg::KIND_CLEAR;
    mreq.wr_isum_en = s1_v_r && en2 && s1_kind_r != tpa_pkg::KIND_CLEAR;
    mreq.wr_rate_en = s1_v_r && en2 &&
                      (s1_kind_r == tpa_pkg::KIND_ROLL || s1_kind_r == tpa_pkg::KIND_PITCH);
    mreq.isum_wdata = s1_sum_cl;
    mreq.rate_wdata = s1_rate_r;
  end

  tpa_state_mem u_state_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mreq),
    .isum_rd (isum_rd),
    .rate_rd (rate_rd)
  );

  // stage 1 load: proportional and integral products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en1) begin
      s1_v_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind_r  <= in_kind;
      s1_rate_r  <= in_rate;
      s1_pprod_r <= 33'(in_err) * 33'($signed({1'b0, gains.prop}));
      s1_iprod_r <= 33'(in_err) * 33'($signed({1'b0, gains.integ}));
      s1_dgain_r <= gains.deriv;
    end
  end

  // integral update with clamp, rate difference
  always_comb begin
    s1_sum_raw = 34'(isum_rd) + 34'(s1_iprod_r);
    if (s1_sum_raw > IntegLim) begin
      s1_sum_cl = 32'(IntegLim);
    end else if (s1_sum_raw < -IntegLim) begin
      s1_sum_cl = 32'(-IntegLim);
    end else begin
      s1_sum_cl = 32'(s1_sum_raw);
    end
    if (s1_kind_r == tpa_pkg::KIND_ROLL || s1_kind_r == tpa_pkg::KIND_PITCH) begin
      s1_diff = 17'(rate_rd) - 17'(s1_rate_r);
    end else begin
      s1_diff = '0;
    end
  end

  // stage 2, clear requests drop out here
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en2) begin
      s2_v_r <= s1_v_r && s1_kind_r != tpa_pkg::KIND_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_kind_r  <= s1_kind_r;
      s2_sum_r   <= s1_sum_cl;
      s2_pprod_r <= s1_pprod_r;
      s2_diff_r  <= s1_diff;
      s2_dgain_r <= s1_dgain_r;
    end
  end

  // stage 3: derivative product, proportional plus integral
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en3) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_kind_r  <= s2_kind_r;
      s3_pt_r    <= 34'(s2_pprod_r) + 34'(s2_sum_r);
      s3_dprod_r <= 34'(s2_diff_r) * 34'($signed({1'b0, s2_dgain_r}));
    end
  end

  assign s3_total = 36'(s3_pt_r) + 36'(s3_dprod_r);

  // stage 4: total sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (en4) begin
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_kind_r  <= s3_kind_r;
      s4_total_r <= s3_total;
    end
  end

  // truncate toward zero, then clamp to the drive limit
  always_comb begin
    s4_q = (s4_total_r + (s4_total_r[35] ? FracMask : 36'sd0)) >>> SumFrac;
    if (s4_q > OutLim) begin
      s4_ctl = OutLim;
    end else if (s4_q < -OutLim) begin
      s4_ctl = -OutLim;
    end else begin
      s4_ctl = s4_q;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en_out) begin
      out_valid_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      out_tdata_r <= {4'b0000, s4_ctl[tpa_pkg::CTL_W-1:0]};
      out_tuser_r <= s4_kind_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // a clear beat never writes back a sum
  a_clr_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    mreq.clr |-> !mreq.wr_isum_en && !mreq.wr_rate_en)
    else $error("clear and write-back in the same cycle");

  // clear beats never reach the output
  a_no_clear_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_tuser_r != tpa_pkg::KIND_CLEAR)
    else $error("result beat carries the clear kind");

  // written integral sum stays inside its clamp
  a_isum_range: assert property (@(posedge clk) disable iff (!rst_n)
    mreq.wr_isum_en |-> (34'(mreq.isum_wdata) <= IntegLim) &&
                        (34'(mreq.isum_wdata) >= -IntegLim))
    else $error("integral sum out of range");

  // an empty pipeline always takes a beat
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (!s1_v_r && !s2_v_r && !s3_v_r && !s4_v_r && !out_valid_r) |-> in_tready)
    else $error("empty pipeline not ready");

endmodule

>>> test/tb_three_axis_pid_attitude.sv
module tb_three_axis_pid_attitude;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MOTOR_MAX = 2000;
  localparam int FRAC_BITS = 4;
  localparam int SUM_FRAC = FRAC_BITS + tpa_pkg::GAIN_FRAC;
  localparam longint ISUM_LIM =
    longint'(MOTOR_MAX - tpa_pkg::INTEG_MARGIN) <<< SUM_FRAC;
  localparam longint CTL_LIM = longint'(MOTOR_MAX - tpa_pkg::OUT_MARGIN);
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct {
    tpa_pkg::tpa_kind_t         kind;
    logic [tpa_pkg::VAL_W-1:0]  err;
    logic [tpa_pkg::VAL_W-1:0]  rate;
  } pid_item_t;

  typedef struct {
    logic [tpa_pkg::KIND_W-1:0] axis;
    logic [tpa_pkg::CTL_W-1:0]  value;
  } control_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // [15:0] angle_error, [31:16] angular_rate
  logic [1:0]  in_tuser = '0;   // [1:0] kind
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // [11:0] control_value, [15:12] zero
  logic [1:0]  out_tuser;       // [1:0] axis
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_wdata = '0;

  // stimulus and predicted results
  pid_item_t pending_beats[$];
  control_t  control_due[$];
  pid_item_t next_beat;
  control_t  due_now;
  logic      calm = 1'b0;
  int        mismatches = 0;
  int        stall_cycles = 0;

  // predictor state
  logic [tpa_pkg::GAIN_W-1:0]        gain_q [tpa_pkg::NUM_REGS];
  logic signed [tpa_pkg::ISUM_W-1:0] isum_q [3];
  logic signed [tpa_pkg::VAL_W-1:0]  prev_rate_q [2];

  three_axis_pid_attitude #(
    .MOTOR_MAX(MOTOR_MAX),
    .FRAC_BITS(FRAC_BITS)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // one controller step: update axis state, queue the expected drive value
  function automatic void predict_control(tpa_pkg::tpa_kind_t k,
                                          logic signed [tpa_pkg::VAL_W-1:0] err,
                                          logic signed [tpa_pkg::VAL_W-1:0] rate);
    longint sum;
    longint total;
    longint ctl;
    int ax;
    int base;
    control_t r;
    if (k == tpa_pkg::KIND_CLEAR) begin
      foreach (isum_q[i]) isum_q[i] = '0;
      return;
    end
    ax = int'(k);
    base = ax * 3;
    sum = longint'(isum_q[ax]) + longint'(err)
          * longint'(gain_q[base + int'(tpa_pkg::REG_ROLL_INTEG)]);
    if (sum > ISUM_LIM) sum = ISUM_LIM;
    if (sum < -ISUM_LIM) sum = -ISUM_LIM;
    isum_q[ax] = sum[tpa_pkg::ISUM_W-1:0];
    total = longint'(err) * longint'(gain_q[base + int'(tpa_pkg::REG_ROLL_PROP)]) + sum;
    // derivative on measurement, roll and pitch only
    if (k != tpa_pkg::KIND_YAW) begin
      total += (longint'(prev_rate_q[ax]) - longint'(rate))
               * longint'(gain_q[base + int'(tpa_pkg::REG_ROLL_DERIV)]);
      prev_rate_q[ax] = rate;
    end
    // integer division truncates toward zero
    ctl = total / (longint'(1) <<< SUM_FRAC);
    if (ctl > CTL_LIM) ctl = CTL_LIM;
    if (ctl < -CTL_LIM) ctl = -CTL_LIM;
    r.axis = ax[tpa_pkg::KIND_W-1:0];
    r.value = ctl[tpa_pkg::CTL_W-1:0];
    control_due.push_back(r);
  endfunction

  task automatic flag_mismatch(string what, control_t e, logic [1:0] got_axis,
                               logic [15:0] got_data);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch (%s): expected axis %0d value %0d, got axis %0d data 0x%h",
               what, e.axis, $signed(e.value), got_axis, got_data);
  endtask

  // input driver, prediction taken at each accepted beat
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        predict_control(tpa_pkg::tpa_kind_t'(in_tuser), in_tdata[15:0], in_tdata[31:16]);
      if (!in_tvalid || in_tready) begin
        if (pending_beats.size() > 0 && (calm || $urandom_range(99) >= 15)) begin
          next_beat = pending_beats.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= next_beat.kind;
          in_tdata <= {next_beat.rate, next_beat.err};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor and random back-pressure
  always @(posedge clk) begin
    out_tready <= calm || ($urandom_range(99) >= 15);
    if (rst_n && out_tvalid && out_tready) begin
      if (control_due.size() == 0) begin
        due_now = '{axis: '0, value: '0};
        flag_mismatch("unexpected beat", due_now, out_tuser, out_tdata);
      end else begin
        due_now = control_due.pop_front();
        if (out_tuser != due_now.axis || out_tdata != {4'b0, due_now.value})
          flag_mismatch("wrong field", due_now, out_tuser, out_tdata);
      end
    end
  end

  // watchdog on cycles without any progress
  always @(posedge clk) begin
    if (!rst_n || cfg_wr_en || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic logic [tpa_pkg::VAL_W-1:0] rand_value();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      4, 5: return 16'($urandom_range(511)) - 16'd256;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [tpa_pkg::GAIN_W-1:0] rand_gain();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hffff;
      2, 3: return 16'($urandom_range(127));
      4, 5: return 16'($urandom_range(4095));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic push_item(tpa_pkg::tpa_kind_t k, logic [tpa_pkg::VAL_W-1:0] err,
                           logic [tpa_pkg::VAL_W-1:0] rate);
    pending_beats.push_back('{kind: k, err: err, rate: rate});
  endtask

  // register writes, only while the block is idle
  task automatic load_gains(input logic [tpa_pkg::GAIN_W-1:0] g [tpa_pkg::NUM_REGS]);
    for (int i = 0; i < tpa_pkg::NUM_REGS; i++) begin
      @(posedge clk);
      cfg_wr_en <= 1'b1;
      cfg_index <= i[tpa_pkg::REG_IDX_W-1:0];
      cfg_wdata <= g[i];
      gain_q[i] = g[i];
    end
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // all beats sent and all results back, then let clear beats drain
  task automatic wait_idle();
    @(negedge clk);
    while (pending_beats.size() > 0 || in_tvalid || control_due.size() > 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [tpa_pkg::GAIN_W-1:0] g [tpa_pkg::NUM_REGS];
    tpa_pkg::tpa_kind_t k;

    gain_q = tpa_pkg::GAIN_RESET;
    foreach (isum_q[i]) isum_q[i] = '0;
    foreach (prev_rate_q[i]) prev_rate_q[i] = '0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset gains: extremes, truncation toward zero, yaw ignoring rate
    push_item(tpa_pkg::KIND_ROLL, 16'h0000, 16'h0000);
    push_item(tpa_pkg::KIND_ROLL, 16'h7fff, 16'h0000);
    push_item(tpa_pkg::KIND_ROLL, 16'h8000, 16'h7fff);
    push_item(tpa_pkg::KIND_PITCH, 16'h0010, 16'h8000);
    push_item(tpa_pkg::KIND_PITCH, 16'hfff0, 16'h0000);
    push_item(tpa_pkg::KIND_ROLL, 16'hffff, 16'hffff);
    push_item(tpa_pkg::KIND_YAW, 16'h7fff, 16'h3039);
    push_item(tpa_pkg::KIND_YAW, 16'h8000, 16'hffff);
    push_item(tpa_pkg::KIND_YAW, 16'h0001, 16'h0000);
    push_item(tpa_pkg::KIND_CLEAR, 16'hffff, 16'hffff);
    push_item(tpa_pkg::KIND_PITCH, 16'h0064, 16'h0064);
    wait_idle();

    // full-scale gains: integral clamp reached in both directions
    foreach (g[i]) g[i] = 16'hffff;
    load_gains(g);
    push_item(tpa_pkg::KIND_ROLL, 16'h7fff, 16'h0000);
    push_item(tpa_pkg::KIND_ROLL, 16'h7fff, 16'h0000);
    push_item(tpa_pkg::KIND_PITCH, 16'h8000, 16'h7fff);
    push_item(tpa_pkg::KIND_PITCH, 16'h8000, 16'h8000);
    push_item(tpa_pkg::KIND_YAW, 16'h8000, 16'h7fff);
    push_item(tpa_pkg::KIND_YAW, 16'h0001, 16'h0000);
    push_item(tpa_pkg::KIND_CLEAR, 16'h0000, 16'h0000);
    push_item(tpa_pkg::KIND_ROLL, 16'h0001, 16'h8000);
    push_item(tpa_pkg::KIND_YAW, 16'hffff, 16'h0000);
    wait_idle();

    // zero gains: only zero drive possible
    foreach (g[i]) g[i] = 16'h0000;
    load_gains(g);
    push_item(tpa_pkg::KIND_ROLL, 16'h7fff, 16'h8000);
    push_item(tpa_pkg::KIND_PITCH, 16'h8000, 16'h7fff);
    push_item(tpa_pkg::KIND_YAW, 16'hffff, 16'hffff);
    wait_idle();

    // random gains and random beats, one phase without idling
    for (int ph = 0; ph < 5; ph++) begin
      foreach (g[i]) g[i] = rand_gain();
      load_gains(g);
      calm = (ph == 2);
      for (int n = 0; n < 80; n++) begin
        if ($urandom_range(99) < 8) k = tpa_pkg::KIND_CLEAR;
        else k = tpa_pkg::tpa_kind_t'($urandom_range(2));
        push_item(k, rand_value(), rand_value());
      end
      wait_idle();
      calm = 1'b0;
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && control_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/tpa_pkg.sv
rtl/core/tpa_gain_regs.sv
rtl/core/tpa_state_mem.sv
rtl/core/three_axis_pid_attitude.sv
test/tb_three_axis_pid_attitude.sv
